[design/assert_macros.svh]
// Assertion macros used by the ring buffer command sequencer.
// The macros expect clk and rst_n to be visible where they are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that holds at every clock edge out of reset.
`define CRB_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// A condition that implies another one in the next cycle.
`define CRB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/crb_pkg.sv]
// Package for the overwriting byte ring buffer: item types, command codes
// and size constants. No dependencies.
package crb_pkg;

  localparam int DATA_W    = 8;
  localparam int CMD_W     = 3;
  localparam int CNT_W     = 6;
  localparam int DEPTH_DEF = 32;
  localparam int STR_CAP   = 32;

  localparam logic [CMD_W-1:0] CMD_PUT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_GET = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP = 3'd2;
  localparam logic [CMD_W-1:0] CMD_STR = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLR = 3'd4;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [DATA_W-1:0] data;
  } in_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] data_res;
    logic              was_empty;
    logic [CNT_W-1:0]  string_length;
    logic [CNT_W-1:0]  fill_count;
    logic              full_res;
    logic              last;
  } out_item_t;

endpackage

[design/crb_mem.sv]
// Byte store of the ring buffer: one write port, one read port with
// registered read data. Depends on crb_pkg.
module crb_mem #(
  parameter int  DEPTH = crb_pkg::DEPTH_DEF,
  localparam int IW    = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [IW-1:0]             waddr,
  input  logic [crb_pkg::DATA_W-1:0] wdata,
  input  logic                      re,
  input  logic [IW-1:0]             raddr,
  output logic [crb_pkg::DATA_W-1:0] rdata_r
);

  logic [crb_pkg::DATA_W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_q[raddr];
    end
  end

endmodule

[design/crb_ctrl.sv]
// Command sequencer of the ring buffer: indices, full flag, string drain
// counter and the memory accesses. Depends on crb_pkg and assert_macros.svh.
`include "assert_macros.svh"

module crb_ctrl #(
  parameter int  DEPTH = crb_pkg::DEPTH_DEF,
  localparam int IW    = $clog2(DEPTH)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  crb_pkg::in_item_t          in_item,
  output logic                       in_ready,
  input  logic                       out_free,
  output logic                       res_load,
  output crb_pkg::out_item_t         res,
  output logic                       mem_we,
  output logic [IW-1:0]              mem_waddr,
  output logic [crb_pkg::DATA_W-1:0] mem_wdata,
  output logic                       mem_re,
  output logic [IW-1:0]              mem_raddr,
  input  logic [crb_pkg::DATA_W-1:0] mem_rdata
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_STR  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  localparam int CW = crb_pkg::CNT_W;

  logic [1:0]    state_r, state_nxt;
  logic [IW-1:0] widx_r, widx_nxt;
  logic [IW-1:0] ridx_r, ridx_nxt;
  logic          full_r, full_nxt;
  logic [CW-1:0] scnt_r, scnt_nxt;
  logic          fin_empty_r, fin_empty_nxt;
  logic          empty;
  logic          accept;

  function automatic logic [IW-1:0] idx_inc(input logic [IW-1:0] i);
    return (i == IW'(DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [IW-1:0] idx_dec(input logic [IW-1:0] i);
    return (i == '0) ? IW'(DEPTH - 1) : i - 1'b1;
  endfunction

  function automatic logic [CW-1:0] held(input logic [IW-1:0] w,
                                         input logic [IW-1:0] r,
                                         input logic f);
    logic [CW-1:0] wc;
    logic [CW-1:0] rc;
    wc = CW'(w);
    rc = CW'(r);
    if (f) begin
      return CW'(DEPTH);
    end else if (w >= r) begin
      return wc - rc;
    end
    return wc + CW'(DEPTH) - rc;
  endfunction

  assign empty    = !full_r && (widx_r == ridx_r);
  assign in_ready = (state_r == S_IDLE) && out_free;
  assign accept   = in_ready && in_valid;

  // Writes happen only on an accepted put and reads only afterwards, so the
  // two memory ports never touch the same slot in one cycle.
  always_comb begin
    state_nxt     = state_r;
    widx_nxt      = widx_r;
    ridx_nxt      = ridx_r;
    full_nxt      = full_r;
    scnt_nxt      = scnt_r;
    fin_empty_nxt = fin_empty_r;
    res_load      = 1'b0;
    res           = '0;
    mem_we        = 1'b0;
    mem_waddr     = widx_r;
    mem_wdata     = in_item.data;
    mem_re        = 1'b0;
    mem_raddr     = ridx_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_item.command)
            crb_pkg::CMD_PUT: begin
              mem_we   = 1'b1;
              ridx_nxt = full_r ? idx_inc(ridx_r) : ridx_r;
              widx_nxt = idx_inc(widx_r);
              full_nxt = (idx_inc(widx_r) == ridx_nxt);
              res_load = 1'b1;
              res.last = 1'b1;
            end
            crb_pkg::CMD_GET: begin
              if (empty) begin
                res_load      = 1'b1;
                res.was_empty = 1'b1;
                res.last      = 1'b1;
              end else begin
                mem_re    = 1'b1;
                ridx_nxt  = idx_inc(ridx_r);
                full_nxt  = 1'b0;
                state_nxt = S_RD;
              end
            end
            crb_pkg::CMD_POP: begin
              if (empty) begin
                res_load      = 1'b1;
                res.was_empty = 1'b1;
                res.last      = 1'b1;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = idx_dec(widx_r);
                widx_nxt  = idx_dec(widx_r);
                full_nxt  = 1'b0;
                state_nxt = S_RD;
              end
            end
            crb_pkg::CMD_STR: begin
              if (empty) begin
                res_load      = 1'b1;
                res.was_empty = 1'b1;
                res.last      = 1'b1;
              end else begin
                mem_re    = 1'b1;
                ridx_nxt  = idx_inc(ridx_r);
                full_nxt  = 1'b0;
                scnt_nxt  = '0;
                state_nxt = S_STR;
              end
            end
            crb_pkg::CMD_CLR: begin
              widx_nxt = ridx_r;
              full_nxt = 1'b0;
              res_load = 1'b1;
              res.last = 1'b1;
            end
            default: begin
              res_load = 1'b1;
              res.last = 1'b1;
            end
          endcase
        end
      end
      S_RD: begin
        if (out_free) begin
          res_load     = 1'b1;
          res.data_res = mem_rdata;
          res.last     = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_STR: begin
        if (out_free) begin
          res_load = 1'b1;
          if (mem_rdata == '0) begin
            // The terminating zero is consumed and closes the run.
            res.string_length = scnt_r;
            res.last          = 1'b1;
            state_nxt         = S_IDLE;
          end else begin
            res.data_res = mem_rdata;
            scnt_nxt     = scnt_r + 1'b1;
            if (scnt_nxt == CW'(crb_pkg::STR_CAP)) begin
              fin_empty_nxt = 1'b0;
              state_nxt     = S_FIN;
            end else if (empty) begin
              fin_empty_nxt = 1'b1;
              state_nxt     = S_FIN;
            end else begin
              mem_re   = 1'b1;
              ridx_nxt = idx_inc(ridx_r);
            end
          end
        end
      end
      S_FIN: begin
        if (out_free) begin
          res_load          = 1'b1;
          res.was_empty     = fin_empty_r;
          res.string_length = scnt_r;
          res.last          = 1'b1;
          state_nxt         = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    // While draining a string, the next byte is fetched in the cycle its
    // predecessor is reported, so the count must come from the current state.
    if (state_r == S_IDLE) begin
      res.fill_count = held(widx_nxt, ridx_nxt, full_nxt);
      res.full_res   = full_nxt;
    end else begin
      res.fill_count = held(widx_r, ridx_r, full_r);
      res.full_res   = full_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      widx_r      <= '0;
      ridx_r      <= '0;
      full_r      <= 1'b0;
      scnt_r      <= '0;
      fin_empty_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      widx_r      <= widx_nxt;
      ridx_r      <= ridx_nxt;
      full_r      <= full_nxt;
      scnt_r      <= scnt_nxt;
      fin_empty_r <= fin_empty_nxt;
    end
  end

  `CRB_ASSERT(a_load_needs_room, !res_load || out_free, "result loaded into a busy output")
  `CRB_ASSERT(a_cap, scnt_r <= CW'(crb_pkg::STR_CAP), "string counter beyond cap")
  `CRB_ASSERT(a_mid_run, !(res_load && !res.last) || (state_r == S_STR), "non-final result outside a string run")
  `CRB_ASSERT(a_full_count, !full_r || (widx_r == ridx_r), "full flag with indices apart")
  `CRB_ASSERT_NEXT(a_read_then_report, accept && mem_re, !in_ready, "read issued but block took a new item")

endmodule

[design/overwriting_char_ring_buffer_unit.sv]
// Top level of the overwriting byte ring buffer: command sequencer, byte
// store and output register. Depends on crb_pkg, crb_ctrl and crb_mem.
//
//   channel | ports                        | payload
//   input   | in_valid, in_stall, in_item  | crb_pkg::in_item_t (command, data)
//   result  | out_valid, out_stall, out_item | crb_pkg::out_item_t
//
// Put, clear and unknown commands load their result when accepted. Get and pop
// on a non-empty buffer read the byte store, which registers its read data, and
// load the byte from the read state; on an empty buffer they load at acceptance.
// Get string on an empty buffer loads at acceptance. Otherwise it loads one result
// per byte drained, plus a final result when the run ends on an empty buffer or
// on the 32 byte cap.
// Reset (rst_n low, synchronous) empties the buffer; the byte store is not cleared.
// A stalled result holds the output register, and the block stops taking items.
module overwriting_char_ring_buffer_unit #(
  parameter int DEPTH = crb_pkg::DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  crb_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output crb_pkg::out_item_t out_item
);

  localparam int IW = $clog2(DEPTH);

  logic                       in_ready;
  logic                       out_free;
  logic                       res_load;
  crb_pkg::out_item_t         res;
  logic                       mem_we;
  logic [IW-1:0]              mem_waddr;
  logic [crb_pkg::DATA_W-1:0] mem_wdata;
  logic                       mem_re;
  logic [IW-1:0]              mem_raddr;
  logic [crb_pkg::DATA_W-1:0] mem_rdata;
  logic                       out_valid_r;
  crb_pkg::out_item_t         out_item_r;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !in_ready;

  crb_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_item   (in_item),
    .in_ready  (in_ready),
    .out_free  (out_free),
    .res_load  (res_load),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  crb_mem #(.DEPTH(DEPTH)) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .re      (mem_re),
    .raddr   (mem_raddr),
    .rdata_r (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_item_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

[verif/crb_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for the overwriting byte ring buffer: watches both channels, keeps
// its own copy of the ring and checks every result item. Depends on crb_pkg.
module crb_checker #(
  parameter int DEPTH = crb_pkg::DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  crb_pkg::in_item_t  in_item,
  input  logic               out_valid,
  input  logic               out_stall,
  input  crb_pkg::out_item_t out_item,
  output int                 fail_count,
  output int                 pending
);

  logic [crb_pkg::DATA_W-1:0] ring_mem [DEPTH];
  int                         wr_ptr;
  int                         rd_ptr;
  bit                         ring_full;
  crb_pkg::out_item_t         due_results [$];
  int                         mismatches;

  initial begin
    mismatches = 0;
  end

  function automatic int held_count();
    return ring_full ? DEPTH : (wr_ptr + DEPTH - rd_ptr) % DEPTH;
  endfunction

  function automatic bit ring_empty();
    return !ring_full && (wr_ptr == rd_ptr);
  endfunction

  // Fill count and full flag are taken from the ring as it stands after the
  // operation that produced this item.
  function automatic crb_pkg::out_item_t result_now(input logic [crb_pkg::DATA_W-1:0] d,
                                                    input bit emp, input int len,
                                                    input bit lst);
    crb_pkg::out_item_t r;
    r.data_res      = d;
    r.was_empty     = emp;
    r.string_length = crb_pkg::CNT_W'(len);
    r.fill_count    = crb_pkg::CNT_W'(held_count());
    r.full_res      = ring_full;
    r.last          = lst;
    return r;
  endfunction

  task automatic take_oldest(output bit ok, output logic [crb_pkg::DATA_W-1:0] v);
    if (ring_empty()) begin
      ok = 1'b0;
      v  = '0;
    end else begin
      ok        = 1'b1;
      v         = ring_mem[rd_ptr];
      ring_full = 1'b0;
      rd_ptr    = (rd_ptr + 1) % DEPTH;
    end
  endtask

  task automatic apply_command(input crb_pkg::in_item_t it);
    logic [crb_pkg::DATA_W-1:0] v;
    bit                         ok;
    int                         n;
    case (it.command)
      crb_pkg::CMD_PUT: begin
        ring_mem[wr_ptr] = it.data;
        if (ring_full) rd_ptr = (rd_ptr + 1) % DEPTH;
        wr_ptr    = (wr_ptr + 1) % DEPTH;
        ring_full = (wr_ptr == rd_ptr);
        due_results.push_back(result_now('0, 1'b0, 0, 1'b1));
      end
      crb_pkg::CMD_GET: begin
        take_oldest(ok, v);
        due_results.push_back(result_now(v, !ok, 0, 1'b1));
      end
      crb_pkg::CMD_POP: begin
        if (ring_empty()) begin
          due_results.push_back(result_now('0, 1'b1, 0, 1'b1));
        end else begin
          wr_ptr    = (wr_ptr + DEPTH - 1) % DEPTH;
          v         = ring_mem[wr_ptr];
          ring_full = 1'b0;
          due_results.push_back(result_now(v, 1'b0, 0, 1'b1));
        end
      end
      crb_pkg::CMD_STR: begin
        n  = 0;
        ok = 1'b1;
        while (n < crb_pkg::STR_CAP) begin
          take_oldest(ok, v);
          if (!ok || v == '0) break;
          due_results.push_back(result_now(v, 1'b0, 0, 1'b0));
          n++;
        end
        // Only a run that found the ring empty flags was_empty on its final item.
        due_results.push_back(result_now('0, !ok, n, 1'b1));
      end
      crb_pkg::CMD_CLR: begin
        wr_ptr    = rd_ptr;
        ring_full = 1'b0;
        due_results.push_back(result_now('0, 1'b0, 0, 1'b1));
      end
      default: begin
        due_results.push_back(result_now('0, 1'b0, 0, 1'b1));
      end
    endcase
  endtask

  always @(posedge clk) begin
    crb_pkg::out_item_t exp_item;
    bit                 bad;
    if (!rst_n) begin
      wr_ptr    = 0;
      rd_ptr    = 0;
      ring_full = 1'b0;
      due_results.delete();
    end else begin
      // A result leaving at this edge always belongs to an earlier item.
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result item data %h empty %b len %0d fill %0d %s",
                     $realtime, out_item.data_res, out_item.was_empty,
                     out_item.string_length, out_item.fill_count,
                     $sformatf("full %b last %b", out_item.full_res, out_item.last));
        end else begin
          exp_item = due_results.pop_front();
          bad = (out_item.data_res      !== exp_item.data_res)      ||
                (out_item.was_empty     !== exp_item.was_empty)     ||
                (out_item.string_length !== exp_item.string_length) ||
                (out_item.fill_count    !== exp_item.fill_count)    ||
                (out_item.full_res      !== exp_item.full_res)      ||
                (out_item.last          !== exp_item.last);
          if (bad) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: mismatch, expected data %h empty %b len %0d fill %0d full %b last %b",
                       $realtime, exp_item.data_res, exp_item.was_empty,
                       exp_item.string_length, exp_item.fill_count, exp_item.full_res,
                       exp_item.last);
              $display("%0t:           actual   data %h empty %b len %0d fill %0d full %b last %b",
                       $realtime, out_item.data_res, out_item.was_empty,
                       out_item.string_length, out_item.fill_count, out_item.full_res,
                       out_item.last);
            end
          end
        end
      end
      if (in_valid && !in_stall) apply_command(in_item);
    end
    fail_count <= mismatches;
    pending    <= due_results.size();
  end

endmodule

[verif/tb_overwriting_char_ring_buffer_unit.sv]
`timescale 1ns / 1ps
// Top of the ring buffer testbench: clock, reset, command stimulus and verdict.
// Depends on crb_pkg, overwriting_char_ring_buffer_unit and crb_checker.
module tb_overwriting_char_ring_buffer_unit;

  localparam logic [crb_pkg::CMD_W-1:0] CMD_RSV_LO  = 3'd5;
  localparam logic [crb_pkg::CMD_W-1:0] CMD_RSV_MID = 3'd6;
  localparam logic [crb_pkg::CMD_W-1:0] CMD_RSV_HI  = 3'd7;
  localparam int RAND_ITEMS   = 300;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 50;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  crb_pkg::in_item_t  in_item   = '0;
  logic               out_stall = 1'b0;
  logic               in_stall;
  logic               out_valid;
  crb_pkg::out_item_t out_item;
  bit                 idle_on   = 1'b1;
  int                 fail_count;
  int                 pending;
  int                 cycles    = 0;
  int                 sent      = 0;

  always #5 clk = ~clk;

  overwriting_char_ring_buffer_unit #(.DEPTH(crb_pkg::DEPTH_DEF)) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  crb_checker #(.DEPTH(crb_pkg::DEPTH_DEF)) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always @(posedge clk) begin
    out_stall <= idle_on && ($urandom_range(99) < 21);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Offers one item, with a random gap in front while idle_on is set, and returns at
  // the edge that accepts it.
  task automatic push_item(input logic [crb_pkg::CMD_W-1:0] cmd,
                           input logic [crb_pkg::DATA_W-1:0] dat);
    while (idle_on && ($urandom_range(99) < 21)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_item.command <= cmd;
    in_item.data    <= dat;
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic push_random_cmd();
    int r;
    r = $urandom_range(99);
    if (r < 40)      push_item(crb_pkg::CMD_PUT, crb_pkg::DATA_W'($urandom_range(255)));
    else if (r < 58) push_item(crb_pkg::CMD_GET, crb_pkg::DATA_W'($urandom_range(255)));
    else if (r < 72) push_item(crb_pkg::CMD_POP, crb_pkg::DATA_W'($urandom_range(255)));
    else if (r < 82) push_item(crb_pkg::CMD_STR, crb_pkg::DATA_W'($urandom_range(255)));
    else if (r < 93) push_item(crb_pkg::CMD_CLR, crb_pkg::DATA_W'($urandom_range(255)));
    else             push_item(crb_pkg::CMD_W'($urandom_range(CMD_RSV_HI, CMD_RSV_LO)),
                               crb_pkg::DATA_W'($urandom_range(255)));
  endtask

  initial begin
    int  kind;
    int  n;
    int  start_sent;
    bit  with_zero;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty ring: get, pop and a string run all report empty.
    push_item(crb_pkg::CMD_GET, 8'h5A);
    push_item(crb_pkg::CMD_POP, 8'hFF);
    push_item(crb_pkg::CMD_STR, 8'h00);
    // Byte extremes; get takes the oldest, pop the newest.
    push_item(crb_pkg::CMD_PUT, 8'h00);
    push_item(crb_pkg::CMD_PUT, 8'hFF);
    push_item(crb_pkg::CMD_PUT, 8'hA5);
    push_item(crb_pkg::CMD_GET, 8'h00);
    push_item(crb_pkg::CMD_POP, 8'h00);
    push_item(crb_pkg::CMD_GET, 8'h00);
    push_item(crb_pkg::CMD_GET, 8'h00);
    // Reserved command codes leave the ring alone.
    push_item(CMD_RSV_LO, 8'hFF);
    push_item(CMD_RSV_HI, 8'h00);
    push_item(CMD_RSV_MID, 8'h3C);
    // A string run stops on a zero byte, the next one on an empty ring.
    push_item(crb_pkg::CMD_PUT, 8'h41);
    push_item(crb_pkg::CMD_PUT, 8'h00);
    push_item(crb_pkg::CMD_PUT, 8'h42);
    push_item(crb_pkg::CMD_STR, 8'h00);
    push_item(crb_pkg::CMD_STR, 8'h00);
    // Clear drops what is held.
    push_item(crb_pkg::CMD_PUT, 8'h11);
    push_item(crb_pkg::CMD_PUT, 8'h22);
    push_item(crb_pkg::CMD_CLR, 8'h00);
    push_item(crb_pkg::CMD_GET, 8'h00);
    push_item(crb_pkg::CMD_POP, 8'h00);
    push_item(crb_pkg::CMD_PUT, 8'h33);
    push_item(crb_pkg::CMD_POP, 8'h00);
    wait_drained();

    start_sent = sent;
    while (sent < start_sent + RAND_ITEMS) begin
      idle_on <= !((sent - start_sent) >= 120 && (sent - start_sent) < 180);
      kind = $urandom_range(99);
      if (kind < 35) begin
        // Short string, possibly terminated, then drained.
        n = $urandom_range(10);
        repeat (n) push_item(crb_pkg::CMD_PUT, crb_pkg::DATA_W'($urandom_range(255, 1)));
        if ($urandom_range(1)) begin
          push_item(crb_pkg::CMD_PUT, 8'h00);
          repeat ($urandom_range(3))
            push_item(crb_pkg::CMD_PUT, crb_pkg::DATA_W'($urandom_range(255, 1)));
        end
        push_item(crb_pkg::CMD_STR, crb_pkg::DATA_W'($urandom_range(255)));
      end else if (kind < 50) begin
        // Thirty to forty puts, which can pass full and overwrite the oldest bytes; a string
        // run on a full ring of non-zero bytes hits the length cap.
        n = $urandom_range(40, 30);
        with_zero = $urandom_range(1);
        repeat (n) begin
          if (with_zero && $urandom_range(15) == 0) push_item(crb_pkg::CMD_PUT, 8'h00);
          else push_item(crb_pkg::CMD_PUT, crb_pkg::DATA_W'($urandom_range(255, 1)));
        end
        if ($urandom_range(1)) push_item(crb_pkg::CMD_STR, 8'h00);
        else repeat ($urandom_range(4, 1))
          push_item($urandom_range(1) ? crb_pkg::CMD_GET : crb_pkg::CMD_POP,
                    crb_pkg::DATA_W'($urandom_range(255)));
      end else if (kind < 90) begin
        push_random_cmd();
      end else if (kind < 95) begin
        push_item(crb_pkg::CMD_CLR, crb_pkg::DATA_W'($urandom_range(255)));
      end else begin
        wait_drained();
        push_random_cmd();
      end
    end

    idle_on <= 1'b1;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+design
design/crb_pkg.sv
design/crb_mem.sv
design/crb_ctrl.sv
design/overwriting_char_ring_buffer_unit.sv
verif/crb_checker.sv
verif/tb_overwriting_char_ring_buffer_unit.sv
